/* design/tblfr_pkg.sv */
// ----------------------------------------------------------------------------
// Two-bit link frame receiver package
// Shared types and constants for the frame receiver and its step logic.
// ----------------------------------------------------------------------------
package tblfr_pkg;

  localparam int unsigned LineW  = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // line bit positions
  localparam int unsigned AckBit   = 2;
  localparam int unsigned ClockBit = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBegin  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEnd    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEscape = 2'd2;

  // reset values of the control codes
  localparam logic [ByteW-1:0] BeginReset  = 8'd2;
  localparam logic [ByteW-1:0] EndReset    = 8'd3;
  localparam logic [ByteW-1:0] EscapeReset = 8'd27;

  // byte position within a frame (saturates at PosBody)
  localparam logic [1:0] PosChecksum = 2'd0;
  localparam logic [1:0] PosFirst    = 2'd1;
  localparam logic [1:0] PosBody     = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] begin_code;
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] escape_code;
  } codes_t;

  typedef struct packed {
    logic [LineW-1:0] line_out;
    logic             byte_valid;
    logic [ByteW-1:0] byte_value;
    logic             frame_done;
    logic             frame_ok;
  } result_t;

endpackage

/* design/tblfr_core.sv */
// ----------------------------------------------------------------------------
// Frame receiver step logic
// Holds the deserializer and framing state and computes one result per
// line sample; the state advances only when step_i is high.
// ----------------------------------------------------------------------------
module tblfr_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [tblfr_pkg::LineW-1:0]     line_i,
  input  tblfr_pkg::codes_t               codes_i,
  output tblfr_pkg::result_t              result_o
);
  import tblfr_pkg::*;

  logic             receiving_q, receiving_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [1:0]       pair_q, pair_d;
  logic             prev_clock_q, prev_clock_d;
  logic             escape_q, escape_d;
  logic             ack_q, ack_d;
  logic [1:0]       pos_q, pos_d;
  logic [ByteW-1:0] rx_sum_q, rx_sum_d;
  logic [ByteW-1:0] run_sum_q, run_sum_d;

  logic             toggle;
  logic [ByteW-1:0] new_shift;
  logic [1:0]       new_pair;
  logic             byte_done;
  logic             is_esc, is_begin, is_end;
  logic             match;

  assign toggle    = line_i[ClockBit] != prev_clock_q;
  assign new_shift = {shift_q[ByteW-3:0], line_i[1:0]};
  assign new_pair  = pair_q + 2'd1;
  assign byte_done = toggle && (new_pair == 2'd0);
  assign is_esc    = new_shift == codes_i.escape_code;
  assign is_begin  = new_shift == codes_i.begin_code;
  assign is_end    = new_shift == codes_i.end_code;
  assign match     = rx_sum_q == run_sum_q;

  always_comb begin
    receiving_d  = receiving_q;
    shift_d      = shift_q;
    pair_d       = pair_q;
    prev_clock_d = prev_clock_q;
    escape_d     = escape_q;
    ack_d        = ack_q;
    pos_d        = pos_q;
    rx_sum_d     = rx_sum_q;
    run_sum_d    = run_sum_q;

    result_o            = '0;
    result_o.line_out   = line_i;

    if (toggle) begin
      prev_clock_d = line_i[ClockBit];
      shift_d      = new_shift;
      pair_d       = new_pair;
    end

    if (!receiving_q) begin
      result_o.line_out[AckBit] = ack_q;
      if (byte_done && is_begin) begin
        receiving_d         = 1'b1;
        escape_d            = 1'b0;
        pos_d               = PosChecksum;
        rx_sum_d            = '0;
        run_sum_d           = '0;
        result_o.byte_valid = 1'b1;
        result_o.byte_value = new_shift;
      end
    end else if (byte_done) begin
      // escape wins over begin, begin over end when codes coincide
      priority if (escape_q && (is_esc || is_begin || is_end)) begin
        escape_d = 1'b0;
      end else if (is_esc) begin
        escape_d = 1'b1;
      end else if (is_begin) begin
        escape_d = escape_q;
      end else if (is_end) begin
        ack_d               = match;
        result_o.frame_done = 1'b1;
        result_o.frame_ok   = match;
        receiving_d         = 1'b0;
      end else begin
        escape_d = escape_q;
      end
      if (pos_q == PosChecksum) begin
        rx_sum_d = new_shift;
        pos_d    = PosFirst;
      end else begin
        run_sum_d = run_sum_q + new_shift;
        pos_d     = PosBody;
      end
      result_o.byte_valid = 1'b1;
      result_o.byte_value = new_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q  <= 1'b0;
      shift_q      <= '0;
      pair_q       <= '0;
      prev_clock_q <= 1'b0;
      escape_q     <= 1'b0;
      ack_q        <= 1'b0;
      pos_q        <= PosChecksum;
      rx_sum_q     <= '0;
      run_sum_q    <= '0;
    end else if (step_i) begin
      receiving_q  <= receiving_d;
      shift_q      <= shift_d;
      pair_q       <= pair_d;
      prev_clock_q <= prev_clock_d;
      escape_q     <= escape_d;
      ack_q        <= ack_d;
      pos_q        <= pos_d;
      rx_sum_q     <= rx_sum_d;
      run_sum_q    <= run_sum_d;
    end
  end

endmodule

/* design/two_bit_link_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Two-bit link frame receiver
// Deserializes a 2-bit clocked line, delimits byte-stuffed frames and checks
// an additive checksum. One result per line sample.
// ----------------------------------------------------------------------------
// Throughput: one line sample per cycle unless out_stall_i holds the output register;
// the input register feeds the step logic, whose result lands in the output
// register, so both can hold an item at once.
// Reset: asynchronous, clears the framing state and loads the default codes
// (begin 2, end 3, escape 27). No clearing pass.
module two_bit_link_frame_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tblfr_pkg::LineW-1:0]     line_in_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tblfr_pkg::LineW-1:0]     line_out_o,
  output logic                            byte_valid_o,
  output logic [tblfr_pkg::ByteW-1:0]     byte_value_o,
  output logic                            frame_done_o,
  output logic                            frame_ok_o,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tblfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tblfr_pkg::ByteW-1:0]     cfg_data_i
);
  import tblfr_pkg::*;

  logic             in_valid_q;
  logic [LineW-1:0] line_q;
  logic             out_valid_q;
  result_t          result_q;
  result_t          result_d;
  codes_t           codes_q;
  logic             advance;

  // input register moves on when the output register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  tblfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .line_i   (line_q),
    .codes_i  (codes_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      line_q <= line_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.begin_code  <= BeginReset;
      codes_q.end_code    <= EndReset;
      codes_q.escape_code <= EscapeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBegin:  codes_q.begin_code  <= cfg_data_i;
        CfgEnd:    codes_q.end_code    <= cfg_data_i;
        CfgEscape: codes_q.escape_code <= cfg_data_i;
        default:   codes_q             <= codes_q;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_out_o   = result_q.line_out;
  assign byte_valid_o = result_q.byte_valid;
  assign byte_value_o = result_q.byte_value;
  assign frame_done_o = result_q.frame_done;
  assign frame_ok_o   = result_q.frame_ok;

endmodule
